// File: src/assert_macros.svh
// Concurrent assertion helpers, clocked on aclk and quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tte_pkg.sv
package tte_pkg;

    localparam int CONC_WIDTH = 32;
    localparam int COEF_W     = 18;
    localparam int COEF_FRAC  = 16;
    localparam int FEED_W     = 31;
    localparam int STEP_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam int PROD_W = CONC_WIDTH + COEF_W + 1;
    localparam int TERM_W = PROD_W - COEF_FRAC;
    localparam int SUM_W  = ((TERM_W > FEED_W + 1) ? TERM_W : (FEED_W + 1)) + 3;

    typedef logic signed [CONC_WIDTH-1:0] conc_t;
    typedef logic        [COEF_W-1:0]     coef_t;
    typedef logic        [FEED_W-1:0]     feed_t;
    typedef logic        [STEP_W-1:0]     step_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [TERM_W-1:0]     term_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;

    // Request codes
    localparam logic REQ_RESTART = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    // Register map
    localparam cfg_idx_t CFG_LOSS_FIRST     = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_GAIN_1_FROM_3  = cfg_idx_t'(1);
    localparam cfg_idx_t CFG_FEED_FIRST     = cfg_idx_t'(2);
    localparam cfg_idx_t CFG_GAIN_2_FROM_1  = cfg_idx_t'(3);
    localparam cfg_idx_t CFG_LOSS_SECOND    = cfg_idx_t'(4);
    localparam cfg_idx_t CFG_GAIN_3_FROM_2  = cfg_idx_t'(5);
    localparam cfg_idx_t CFG_LOSS_THIRD     = cfg_idx_t'(6);
    localparam cfg_idx_t CFG_FEED_THIRD     = cfg_idx_t'(7);

    localparam step_t STEP_MAX = '1;
    localparam prod_t ROUND_HALF = prod_t'(1) <<< (COEF_FRAC - 1);

    // round(c * k / 2^COEF_FRAC), ties toward plus infinity
    function automatic term_t scale_term(input conc_t c, input coef_t k);
        prod_t p;
        prod_t pr;
        p  = prod_t'(c) * prod_t'({1'b0, k});
        pr = p + ROUND_HALF;
        return pr[PROD_W-1:COEF_FRAC];
    endfunction

    // Clamp a wide sum to the signed concentration range
    function automatic conc_t conc_sat(input sum_t s);
        logic [SUM_W-CONC_WIDTH-1:0] upper;
        upper = s[SUM_W-2:CONC_WIDTH-1];
        if (!s[SUM_W-1] && (|upper)) begin
            return {1'b0, {(CONC_WIDTH-1){1'b1}}};
        end else if (s[SUM_W-1] && !(&upper)) begin
            return {1'b1, {(CONC_WIDTH-1){1'b0}}};
        end
        return s[CONC_WIDTH-1:0];
    endfunction

endpackage

// File: src/three_tank_euler_step.sv
// Three-tank forward Euler integrator.
// Input channel (s_valid/s_ready): each item is a restart (s_req_type 0),
// which loads s_init_* and yields step 0, or an advance (s_req_type 1),
// which moves all three concentrations forward one Euler step from the
// previous levels and yields the incremented step index (held at 65535).
// Result channel (m_valid/m_ready): one item per input item, in order.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes the eight
// coefficient registers; cfg_ready is always high; unknown indexes drop.
// Each result is computed combinationally and registered before it appears on m_*.
// Throughput: one item per clock while s_ready is high. The six coefficient
// multiplies run in parallel between the level registers and the result
// register, so the recurrence needs no extra register stage.
// Stall: a two-entry output (result register plus skid register) lets one
// more item enter while a result waits; s_ready drops only when both hold.
// Reset (aresetn low, synchronous): clears levels, step count, coefficient
// registers and both output valid flags; nothing is pending afterward.
module three_tank_euler_step (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_req_type,
    input  tte_pkg::conc_t           s_init_first,
    input  tte_pkg::conc_t           s_init_second,
    input  tte_pkg::conc_t           s_init_third,
    output logic                     m_valid,
    input  logic                     m_ready,
    output tte_pkg::step_t           m_step_index,
    output tte_pkg::conc_t           m_conc_first,
    output tte_pkg::conc_t           m_conc_second,
    output tte_pkg::conc_t           m_conc_third,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  tte_pkg::cfg_idx_t        cfg_index,
    input  logic [tte_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tte_pkg::*;

`include "assert_macros.svh"

    typedef struct packed {
        step_t step;
        conc_t c1;
        conc_t c2;
        conc_t c3;
    } result_t;

    // Coefficient registers
    coef_t loss1_reg, gain13_reg, gain21_reg, loss2_reg, gain32_reg, loss3_reg;
    feed_t feed1_reg, feed3_reg;

    // Integrator state
    conc_t lvl1_reg, lvl2_reg, lvl3_reg;
    step_t step_reg;

    // Output entries
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic    s_accept, m_take;
    result_t res_next;
    term_t   t13, t11, t21, t22, t32, t33;
    sum_t    sum1, sum2, sum3;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign s_accept  = s_valid && s_ready;
    assign m_take    = out_valid_reg && m_ready;

    assign m_valid       = out_valid_reg;
    assign m_step_index  = out_reg.step;
    assign m_conc_first  = out_reg.c1;
    assign m_conc_second = out_reg.c2;
    assign m_conc_third  = out_reg.c3;

    // Coefficient register writes; drop indexes beyond the map
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loss1_reg  <= '0;
            gain13_reg <= '0;
            feed1_reg  <= '0;
            gain21_reg <= '0;
            loss2_reg  <= '0;
            gain32_reg <= '0;
            loss3_reg  <= '0;
            feed3_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_LOSS_FIRST:    loss1_reg  <= cfg_data[COEF_W-1:0];
                CFG_GAIN_1_FROM_3: gain13_reg <= cfg_data[COEF_W-1:0];
                CFG_FEED_FIRST:    feed1_reg  <= cfg_data[FEED_W-1:0];
                CFG_GAIN_2_FROM_1: gain21_reg <= cfg_data[COEF_W-1:0];
                CFG_LOSS_SECOND:   loss2_reg  <= cfg_data[COEF_W-1:0];
                CFG_GAIN_3_FROM_2: gain32_reg <= cfg_data[COEF_W-1:0];
                CFG_LOSS_THIRD:    loss3_reg  <= cfg_data[COEF_W-1:0];
                CFG_FEED_THIRD:    feed3_reg  <= cfg_data[FEED_W-1:0];
                default: ;
            endcase
        end
    end

    // One Euler step: six independent scaled products, then exact sums
    always_comb begin
        t13 = scale_term(lvl3_reg, gain13_reg);
        t11 = scale_term(lvl1_reg, loss1_reg);
        t21 = scale_term(lvl1_reg, gain21_reg);
        t22 = scale_term(lvl2_reg, loss2_reg);
        t32 = scale_term(lvl2_reg, gain32_reg);
        t33 = scale_term(lvl3_reg, loss3_reg);

        sum1 = sum_t'(lvl1_reg) + $signed(SUM_W'(feed1_reg)) + sum_t'(t13) - sum_t'(t11);
        sum2 = sum_t'(lvl2_reg) + sum_t'(t21) - sum_t'(t22);
        sum3 = sum_t'(lvl3_reg) + $signed(SUM_W'(feed3_reg)) + sum_t'(t32) - sum_t'(t33);

        if (s_req_type == REQ_RESTART) begin
            res_next.step = '0;
            res_next.c1   = s_init_first;
            res_next.c2   = s_init_second;
            res_next.c3   = s_init_third;
        end else begin
            res_next.step = (step_reg == STEP_MAX) ? step_reg : step_reg + step_t'(1);
            res_next.c1   = conc_sat(sum1);
            res_next.c2   = conc_sat(sum2);
            res_next.c3   = conc_sat(sum3);
        end
    end

    // Advance the state on every accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl1_reg <= '0;
            lvl2_reg <= '0;
            lvl3_reg <= '0;
            step_reg <= '0;
        end else if (s_accept) begin
            lvl1_reg <= res_next.c1;
            lvl2_reg <= res_next.c2;
            lvl3_reg <= res_next.c3;
            step_reg <= res_next.step;
        end
    end

    // Output control: result register first, skid register when it is held
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (s_accept) begin
            out_valid_reg <= 1'b1;
            if (out_valid_reg && !m_ready) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_take) begin
                out_reg <= skid_reg;
            end
        end else if (s_accept) begin
            if (!out_valid_reg || m_ready) begin
                out_reg <= res_next;
            end else begin
                skid_reg <= res_next;
            end
        end
    end

    `ASSERT_ALWAYS(a_skid_needs_out, !skid_valid_reg || out_valid_reg, "skid full with output empty")
    `ASSERT_NEXT(a_stall_fills_skid, s_accept && out_valid_reg && !m_ready, skid_valid_reg, "stalled item lost")
    `ASSERT_NEXT(a_restart_zero, s_accept && (s_req_type == REQ_RESTART), step_reg == '0, "restart step not zero")
    `ASSERT_NEXT(a_state_holds, !s_accept, $stable(step_reg) && $stable(lvl1_reg), "state moved without item")

endmodule

// File: tb/three_tank_euler_step_tb.sv
`timescale 1ns / 1ps

module three_tank_euler_step_tb;
    import tte_pkg::*;

    // Watchdog: the slowest correct run stays far below this many cycles.
    localparam int CYCLE_LIMIT = 100_000;
    // Random items, spread over four idling phases.
    localparam int RANDOM_ITEMS = 1900;
    localparam int N_DIRECTED = 21;
    // Indexes past the register list; the block must drop these writes.
    localparam cfg_idx_t CFG_BEYOND_LIST = cfg_idx_t'(8);
    localparam cfg_idx_t CFG_TOP_INDEX = cfg_idx_t'(255);

    localparam longint CONC_HI = (longint'(1) <<< (CONC_WIDTH - 1)) - 1;
    localparam longint CONC_LO = -CONC_HI - 1;

    typedef enum logic [2:0] {
        SET_KEEP, SET_MAX, SET_HALF, SET_MILD, SET_RAND_MILD, SET_RAND_WIDE
    } tank_setting_e;

    typedef struct packed {
        step_t step;
        conc_t first;
        conc_t second;
        conc_t third;
    } tank_point_t;

    // Expected point fixed by hand, or left to the predictor.
    typedef struct packed {
        logic        typed;
        tank_point_t point;
    } pinned_point_t;

    typedef struct packed {
        tank_setting_e setting;
        logic          req;
        conc_t         init_first;
        conc_t         init_second;
        conc_t         init_third;
        logic          typed;
        step_t         e_step;
        conc_t         e_first;
        conc_t         e_second;
        conc_t         e_third;
    } dir_row_t;

    // Directed stimulus. Rows with typed = 1 carry an expectation read off by
    // hand; the rest go through the predictor. A setting other than SET_KEEP
    // is written once the block has drained, before that row's item.
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // advance before any restart: levels are still zero
        '{SET_KEEP, REQ_ADVANCE, 32'h0, 32'h0, 32'h0,
          1'b1, 16'd1, 32'h0, 32'h0, 32'h0},
        // advance ignores the init fields
        '{SET_KEEP, REQ_ADVANCE, 32'hDEAD_BEEF, 32'h1234_5678, 32'h0F0F_0F0F,
          1'b1, 16'd2, 32'h0, 32'h0, 32'h0},
        '{SET_KEEP, REQ_RESTART, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
          1'b1, 16'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF},
        // zero coefficients hold the levels
        '{SET_KEEP, REQ_ADVANCE, 32'h0, 32'h0, 32'h0,
          1'b1, 16'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF},
        '{SET_KEEP, REQ_RESTART, 32'h0, 32'h1, 32'hFFFF_FFFE,
          1'b1, 16'd0, 32'h0, 32'h1, 32'hFFFF_FFFE},
        '{SET_KEEP, REQ_RESTART, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
          1'b1, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0},
        // largest factors and feeds: every sum saturates
        '{SET_MAX, REQ_ADVANCE, 32'h0, 32'h0, 32'h0,
          1'b0, 16'd0, 32'h0, 32'h0, 32'h0},
        '{SET_KEEP, REQ_ADVANCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b0, 16'd0, 32'h0, 32'h0, 32'h0},
        '{SET_KEEP, REQ_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b1, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{SET_KEEP, REQ_ADVANCE, 32'h0, 32'h0, 32'h0,
          1'b0, 16'd0, 32'h0, 32'h0, 32'h0},
        '{SET_KEEP, REQ_RESTART, 32'h1, 32'h1, 32'h1,
          1'b1, 16'd0, 32'h1, 32'h1, 32'h1},
        '{SET_KEEP, REQ_ADVANCE, 32'h0, 32'h0, 32'h0,
          1'b0, 16'd0, 32'h0, 32'h0, 32'h0},
        // half factors: odd levels land exactly on a rounding tie
        '{SET_HALF, REQ_RESTART, 32'h1, 32'hFFFF_FFFF, 32'h3,
          1'b1, 16'd0, 32'h1, 32'hFFFF_FFFF, 32'h3},
        '{SET_KEEP, REQ_ADVANCE, 32'h0, 32'h0, 32'h0,
          1'b0, 16'd0, 32'h0, 32'h0, 32'h0},
        '{SET_KEEP, REQ_RESTART, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          1'b1, 16'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
        '{SET_KEEP, REQ_ADVANCE, 32'h0, 32'h0, 32'h0,
          1'b0, 16'd0, 32'h0, 32'h0, 32'h0},
        // small, plausible plant: a smooth transient
        '{SET_MILD, REQ_RESTART, 32'h000A_0000, 32'h0, 32'hFFF6_0000,
          1'b1, 16'd0, 32'h000A_0000, 32'h0, 32'hFFF6_0000},
        '{SET_KEEP, REQ_ADVANCE, 32'h0, 32'h0, 32'h0,
          1'b0, 16'd0, 32'h0, 32'h0, 32'h0},
        '{SET_KEEP, REQ_ADVANCE, 32'h0, 32'h0, 32'h0,
          1'b0, 16'd0, 32'h0, 32'h0, 32'h0},
        '{SET_KEEP, REQ_ADVANCE, 32'h0, 32'h0, 32'h0,
          1'b0, 16'd0, 32'h0, 32'h0, 32'h0},
        '{SET_KEEP, REQ_ADVANCE, 32'h0, 32'h0, 32'h0,
          1'b0, 16'd0, 32'h0, 32'h0, 32'h0}
    };

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    logic s_req_type = REQ_RESTART;
    conc_t s_init_first = '0;
    conc_t s_init_second = '0;
    conc_t s_init_third = '0;

    logic m_valid;
    logic m_ready = 1'b0;
    step_t m_step_index;
    conc_t m_conc_first;
    conc_t m_conc_second;
    conc_t m_conc_third;

    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_idx_t cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state: register file, one slot per index, and the tank levels.
    logic [31:0] tank_reg [256] = '{default: '0};
    conc_t lvl_first = '0;
    conc_t lvl_second = '0;
    conc_t lvl_third = '0;
    step_t step_cnt = '0;

    tank_point_t pending_points [$];
    pinned_point_t typed_points [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int items_accepted = 0;
    int points_checked = 0;
    int clamped_levels = 0;

    three_tank_euler_step DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_init_first  (s_init_first),
        .s_init_second (s_init_second),
        .s_init_third  (s_init_third),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_step_index  (m_step_index),
        .m_conc_first  (m_conc_first),
        .m_conc_second (m_conc_second),
        .m_conc_third  (m_conc_third),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Round c * k / 2^16 to nearest, ties toward plus infinity: add half an
    // LSB to the exact product and floor with an arithmetic shift.
    function automatic longint flow_term(conc_t c, logic [31:0] k);
        longint prod;
        prod = longint'(c) * longint'(k[COEF_W-1:0]);
        return (prod + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    endfunction

    function automatic conc_t clamp_conc(longint v);
        if (v > CONC_HI) return conc_t'(CONC_HI);
        if (v < CONC_LO) return conc_t'(CONC_LO);
        return conc_t'(v);
    endfunction

    function automatic logic is_feed(cfg_idx_t idx);
        return (idx == CFG_FEED_FIRST) || (idx == CFG_FEED_THIRD);
    endfunction

    // Mirror one register write; drop indexes past the list.
    function automatic void store_register(cfg_idx_t idx, logic [31:0] data);
        if (idx <= CFG_FEED_THIRD) begin
            tank_reg[idx] = is_feed(idx) ? (data & 32'h7FFF_FFFF) : (data & 32'h0003_FFFF);
        end
    endfunction

    // Advance the predicted tanks by one item and return the point it yields.
    // Every update reads the old levels.
    function automatic tank_point_t step_tanks(logic req, conc_t a, conc_t b, conc_t c);
        longint n1;
        longint n2;
        longint n3;
        tank_point_t pt;
        if (req == REQ_RESTART) begin
            lvl_first = a;
            lvl_second = b;
            lvl_third = c;
            step_cnt = '0;
        end else begin
            n1 = longint'(lvl_first) + longint'(tank_reg[CFG_FEED_FIRST])
               + flow_term(lvl_third, tank_reg[CFG_GAIN_1_FROM_3])
               - flow_term(lvl_first, tank_reg[CFG_LOSS_FIRST]);
            n2 = longint'(lvl_second)
               + flow_term(lvl_first, tank_reg[CFG_GAIN_2_FROM_1])
               - flow_term(lvl_second, tank_reg[CFG_LOSS_SECOND]);
            n3 = longint'(lvl_third) + longint'(tank_reg[CFG_FEED_THIRD])
               + flow_term(lvl_second, tank_reg[CFG_GAIN_3_FROM_2])
               - flow_term(lvl_third, tank_reg[CFG_LOSS_THIRD]);
            lvl_first = clamp_conc(n1);
            lvl_second = clamp_conc(n2);
            lvl_third = clamp_conc(n3);
            // hold the counter once it is full
            if (step_cnt != STEP_MAX) step_cnt = step_cnt + 1'b1;
        end
        pt.step = step_cnt;
        pt.first = lvl_first;
        pt.second = lvl_second;
        pt.third = lvl_third;
        return pt;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Observe all three channels at each rising edge. Driven inputs and DUT
    // outputs are read with their pre-edge values, so there is no race.
    always @(posedge aclk) begin : observe
        pinned_point_t pin;
        tank_point_t pt;
        tank_point_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d points still pending",
                     cycle_count, pending_points.size());
            $display("TEST FAILED");
            $finish;
        end
        if (aresetn) begin
            if (cfg_valid && cfg_ready) store_register(cfg_index, cfg_data);
            // Predict on input acceptance; a hand-typed point overrides it.
            if (s_valid && s_ready) begin
                pin = typed_points.pop_front();
                pt = step_tanks(s_req_type, s_init_first, s_init_second, s_init_third);
                pending_points.push_back(pin.typed ? pin.point : pt);
                items_accepted++;
            end
            if (m_valid && m_ready) begin
                if (pending_points.size() == 0) begin
                    $error("result item with no pending expectation");
                    fail_count++;
                end else begin
                    want = pending_points.pop_front();
                    check_field("step_index", longint'(want.step), longint'(m_step_index));
                    check_field("conc_first", longint'(want.first), longint'(m_conc_first));
                    check_field("conc_second", longint'(want.second), longint'(m_conc_second));
                    check_field("conc_third", longint'(want.third), longint'(m_conc_third));
                    points_checked++;
                    if (want.first == conc_t'(CONC_HI) || want.first == conc_t'(CONC_LO))
                        clamped_levels++;
                end
            end
        end
    end

    // Receiver: stall at random per cycle, as the current phase asks.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Offer one item. Idle first for a random gap, then hold valid and the
    // payload until the handshake. Valid stays high into the next item.
    task automatic send_item(logic req, conc_t a, conc_t b, conc_t c,
                             logic typed, tank_point_t point);
        int gap;
        pinned_point_t pin;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        pin.typed = typed;
        pin.point = point;
        typed_points.push_back(pin);
        s_valid <= 1'b1;
        s_req_type <= req;
        s_init_first <= a;
        s_init_second <= b;
        s_init_third <= c;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // Drop valid and wait until every pending point has come back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
    endtask

    // Write all eight registers for one setting, plus two writes the block
    // must drop. Call only while idle.
    task automatic apply_setting(tank_setting_e setting);
        logic [31:0] data;
        for (int i = int'(CFG_LOSS_FIRST); i <= int'(CFG_FEED_THIRD); i++) begin
            case (setting)
                SET_MAX: begin
                    data = 32'hFFFF_FFFF;
                end
                SET_HALF: begin
                    data = is_feed(cfg_idx_t'(i)) ? 32'h0 : 32'h0000_8000;
                end
                SET_MILD: begin
                    data = is_feed(cfg_idx_t'(i)) ? 32'h0000_4000 : 32'h0000_0800;
                end
                SET_RAND_MILD: begin
                    // garbage above the register width must be masked
                    data = $urandom;
                    if (is_feed(cfg_idx_t'(i)))
                        data[30:0] = 31'($urandom_range(0, 32'h0004_0000));
                    else
                        data[17:0] = 18'($urandom_range(0, 4096));
                end
                default: begin
                    data = $urandom;
                end
            endcase
            write_reg(cfg_idx_t'(i), data);
        end
        write_reg(CFG_BEYOND_LIST, $urandom);
        write_reg(CFG_TOP_INDEX, $urandom);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Concentration with weight on the rails and on small values.
    function automatic conc_t pick_conc();
        case ($urandom_range(0, 7))
            0: return conc_t'(CONC_HI);
            1: return conc_t'(CONC_LO);
            2: return conc_t'($urandom_range(0, 32'h0010_0000));
            3: return -conc_t'($urandom_range(0, 32'h0010_0000));
            default: return conc_t'($urandom);
        endcase
    endfunction

    initial begin
        tank_point_t tp;
        tank_setting_e phase_set [4];
        int phase_send [4];
        int phase_recv [4];
        phase_set = '{SET_RAND_WIDE, SET_RAND_MILD, SET_RAND_WIDE, SET_RAND_MILD};
        phase_send = '{0, 72, 0, 19};
        phase_recv = '{0, 0, 72, 19};
        tp = '0;

        // Hold reset once, then release it.
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table, light idling on both sides.
        send_idle_pct = 19;
        recv_stall_pct = 19;
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (DIRECTED[r].setting != SET_KEEP) begin
                drain();
                apply_setting(DIRECTED[r].setting);
            end
            tp.step = DIRECTED[r].e_step;
            tp.first = DIRECTED[r].e_first;
            tp.second = DIRECTED[r].e_second;
            tp.third = DIRECTED[r].e_third;
            send_item(DIRECTED[r].req, DIRECTED[r].init_first, DIRECTED[r].init_second,
                      DIRECTED[r].init_third, DIRECTED[r].typed, tp);
        end

        // Random phases: mostly advance runs, broken by restarts.
        for (int p = 0; p < 4; p++) begin
            drain();
            send_idle_pct = phase_send[p];
            recv_stall_pct = phase_recv[p];
            apply_setting(phase_set[p]);
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                if ($urandom_range(0, 99) < 8)
                    send_item(REQ_RESTART, pick_conc(), pick_conc(), pick_conc(), 1'b0, tp);
                else
                    send_item(REQ_ADVANCE, conc_t'($urandom), conc_t'($urandom),
                              conc_t'($urandom), 1'b0, tp);
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        $display("Checked %0d results against %0d accepted items over %0d cycles",
                 points_checked, items_accepted, cycle_count);
        $display("Tank one sat at a rail in %0d results", clamped_levels);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
